>>> rtl/yrc_pkg.sv
// ----------------------------------------------------------------------------
// yrc_pkg
// Shared types and BT.601 fixed-point constants for the 4:2:0 to RGB converter.
// ----------------------------------------------------------------------------
package yrc_pkg;

    // Fixed-point coefficients with 20 fractional bits.
    localparam logic [20:0]        COEF_Y  = 21'd1220542;
    localparam logic signed [31:0] COEF_UB = 32'sd2116026;
    localparam logic signed [31:0] COEF_UG = -32'sd409993;
    localparam logic signed [31:0] COEF_VG = -32'sd852492;
    localparam logic signed [31:0] COEF_VR = 32'sd1673527;
    localparam int                 FRAC_BITS = 20;
    localparam logic signed [31:0] ROUND_HALF = 32'sd1 <<< (FRAC_BITS - 1);
    localparam logic [7:0]         LUMA_OFS   = 8'd16;
    localparam logic signed [8:0]  CHROMA_OFS = 9'sd128;
    localparam logic [7:0]         ALPHA_OPAQUE = 8'hff;

    localparam int NUM_PIX  = 4;
    localparam int PIX_IDX_W = 2;

    // Register indexes on the configuration port.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WITH_ALPHA = 2'd1;

    typedef struct packed {
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } in_beat_t;

    typedef struct packed {
        logic       pixel_row;
        logic       pixel_col;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [7:0] fourth_byte;
        logic       last;
    } out_beat_t;

    // Chroma contributions shared by all four pixels, rounding half included.
    typedef struct packed {
        logic signed [31:0] red;
        logic signed [31:0] green;
        logic signed [31:0] blue;
    } chroma_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic blue_first;
        logic with_alpha;
    } cfg_t;

endpackage

>>> rtl/yrc_chroma.sv
// ----------------------------------------------------------------------------
// yrc_chroma
// Computes and registers the red, green and blue chroma terms of one block.
// ----------------------------------------------------------------------------
module yrc_chroma (
    input  logic             aclk,
    input  logic             en,
    input  logic [7:0]       chroma_blue,
    input  logic [7:0]       chroma_red,
    output yrc_pkg::chroma_t terms_reg
);
    import yrc_pkg::*;

    logic signed [8:0] u_c;
    logic signed [8:0] v_c;
    chroma_t           terms_next;

    always_comb begin
        u_c = $signed({1'b0, chroma_blue}) - CHROMA_OFS;
        v_c = $signed({1'b0, chroma_red}) - CHROMA_OFS;
        terms_next.red   = ROUND_HALF + COEF_VR * 32'(v_c);
        terms_next.green = ROUND_HALF + COEF_VG * 32'(v_c) + COEF_UG * 32'(u_c);
        terms_next.blue  = ROUND_HALF + COEF_UB * 32'(u_c);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            terms_reg <= terms_next;
        end
    end

endmodule

>>> rtl/yrc_lane.sv
// ----------------------------------------------------------------------------
// yrc_lane
// One pixel lane: luma gain product, then add chroma, shift and saturate.
// ----------------------------------------------------------------------------
module yrc_lane (
    input  logic             aclk,
    input  logic             en,
    input  logic [7:0]       luma,
    input  yrc_pkg::chroma_t terms,
    output yrc_pkg::rgb_t    pix_reg
);
    import yrc_pkg::*;

    logic [7:0]  luma_c;
    logic [28:0] ys_reg;
    logic [28:0] ys_next;
    logic signed [31:0] ys_s;
    rgb_t        pix_next;

    function automatic logic [7:0] scale_sat(input logic signed [31:0] acc);
        logic signed [31:0] val;
        val = acc >>> FRAC_BITS;
        if (val < 0) begin
            scale_sat = 8'd0;
        end else if (val > 32'sd255) begin
            scale_sat = 8'hff;
        end else begin
            scale_sat = val[7:0];
        end
    endfunction

    always_comb begin
        // clamp luma below black level to zero
        luma_c  = (luma >= LUMA_OFS) ? (luma - LUMA_OFS) : 8'd0;
        ys_next = 29'(COEF_Y * 29'(luma_c));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ys_reg <= ys_next;
        end
    end

    always_comb begin
        ys_s           = $signed({3'b000, ys_reg});
        pix_next.red   = scale_sat(ys_s + terms.red);
        pix_next.green = scale_sat(ys_s + terms.green);
        pix_next.blue  = scale_sat(ys_s + terms.blue);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pix_reg <= pix_next;
        end
    end

endmodule

>>> rtl/yrc_merge.sv
// ----------------------------------------------------------------------------
// yrc_merge
// Collects the four lane pixels and sends them one beat per cycle while m_ready
// is high, in raster order, applying byte order and alpha.
// ----------------------------------------------------------------------------
module yrc_merge (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  yrc_pkg::cfg_t                     cfg,
    input  logic                              load,
    input  yrc_pkg::rgb_t [yrc_pkg::NUM_PIX-1:0] pix,
    output logic                              take,
    output logic                              m_valid,
    input  logic                              m_ready,
    output yrc_pkg::out_beat_t                m_data
);
    import yrc_pkg::*;

    localparam logic [PIX_IDX_W-1:0] LAST_IDX = PIX_IDX_W'(NUM_PIX - 1);

    rgb_t [NUM_PIX-1:0]   pix_buf_reg;
    logic [PIX_IDX_W-1:0] cnt_reg;
    logic [PIX_IDX_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 beat_done;
    rgb_t                 cur;

    assign beat_done = busy_reg && m_ready;
    // free now, or the last pixel leaves this cycle
    assign take      = !busy_reg || (beat_done && (cnt_reg == LAST_IDX));
    assign m_valid   = busy_reg;

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (load) begin
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (beat_done) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_IDX) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pix_buf_reg <= pix;
        end
    end

    always_comb begin
        cur                = pix_buf_reg[cnt_reg];
        m_data.pixel_row   = cnt_reg[1];
        m_data.pixel_col   = cnt_reg[0];
        m_data.first_byte  = cfg.blue_first ? cur.blue : cur.red;
        m_data.second_byte = cur.green;
        m_data.third_byte  = cfg.blue_first ? cur.red : cur.blue;
        m_data.fourth_byte = cfg.with_alpha ? ALPHA_OPAQUE : 8'd0;
        m_data.last        = (cnt_reg == LAST_IDX);
    end

endmodule

>>> rtl/yuv420_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// yuv420_to_rgb_converter_top
// BT.601 4:2:0 block to RGB converter: four pixel lanes and a merge stage.
// ----------------------------------------------------------------------------
//  Channel  | Ports                          | Beat
//  ---------+--------------------------------+-------------------------------
//  input    | s_valid, s_ready, s_data       | one 2x2 luma block + U, V
//  output   | m_valid, m_ready, m_data       | one pixel, raster order
//  config   | cfg_wr_en, cfg_index, cfg_wr_data | register write, no wait
//
//  Path: chroma and luma product registers, lane pixel registers, merge buffer.
//  Throughput: the merge stage sends one pixel per cycle while m_ready is high;
//  the next block is taken while pixels still drain.
//  Reset: synchronous active-low aresetn clears valid and counter state;
//  blue_first resets to 1, with_alpha to 0.
//  Stalls: m_ready low holds the merge; the lanes hold once their last stage fills.
// ----------------------------------------------------------------------------
module yuv420_to_rgb_converter_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  yrc_pkg::in_beat_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output yrc_pkg::out_beat_t              m_data,
    input  logic                            cfg_wr_en,
    input  logic [yrc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic                            cfg_wr_data
);
    import yrc_pkg::*;

    cfg_t                  cfg_reg;
    cfg_t                  cfg_next;
    logic                  v1_reg;
    logic                  v2_reg;
    logic                  adv;
    logic                  take;
    logic                  load;
    logic [NUM_PIX-1:0][7:0] luma_in;
    chroma_t               terms;
    rgb_t [NUM_PIX-1:0]    pix;

    // lane order follows raster order of the block
    assign luma_in = {s_data.luma_bottom_right, s_data.luma_bottom_left,
                      s_data.luma_top_right, s_data.luma_top_left};

    // advance the pipe when its last stage is empty or the merge takes it
    assign adv     = !v2_reg || take;
    assign load    = v2_reg && take;
    assign s_ready = adv;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BLUE_FIRST: cfg_next.blue_first = cfg_wr_data;
                CFG_WITH_ALPHA: cfg_next.with_alpha = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blue_first <= 1'b1;
            cfg_reg.with_alpha <= 1'b0;
            v1_reg             <= 1'b0;
            v2_reg             <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
            if (adv) begin
                v1_reg <= s_valid;
                v2_reg <= v1_reg;
            end
        end
    end

    yrc_chroma u_chroma (
        .aclk        (aclk),
        .en          (adv),
        .chroma_blue (s_data.chroma_blue),
        .chroma_red  (s_data.chroma_red),
        .terms_reg   (terms)
    );

    for (genvar k = 0; k < NUM_PIX; k++) begin : g_lane
        yrc_lane u_lane (
            .aclk    (aclk),
            .en      (adv),
            .luma    (luma_in[k]),
            .terms   (terms),
            .pix_reg (pix[k])
        );
    end

    yrc_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .load    (load),
        .pix     (pix),
        .take    (take),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A finished block waiting on a busy merge stage must not be dropped.
    a_hold_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !take) |=> v2_reg)
        else $error("pending block lost while merge busy");

    // An accepted input beat enters the first stage.
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted beat not captured");

    // Pixels of a block leave without gaps once started.
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last) |=> m_valid)
        else $error("output gap inside a block");

endmodule

>>> tb/yrc_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrc_pixel_checker
// Watches the block and pixel channels of the 4:2:0 to RGB converter, keeps
// its own copy of the byte-order and alpha registers, predicts the four
// pixels of every accepted block in fixed point and compares each pixel beat
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module yrc_pixel_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  yrc_pkg::in_beat_t             s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  yrc_pkg::out_beat_t            m_data,
    input  logic                          cfg_wr_en,
    input  logic [yrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                          cfg_wr_data,
    output int                            fail_count,
    output int                            pend_count
);
    import yrc_pkg::*;

    localparam longint LUMA_GAIN   = 1220542;
    localparam longint CB_TO_BLUE  = 2116026;
    localparam longint CB_TO_GREEN = -409993;
    localparam longint CR_TO_GREEN = -852492;
    localparam longint CR_TO_RED   = 1673527;
    localparam int     FRAC        = 20;
    localparam longint ROUND       = longint'(1) <<< (FRAC - 1);
    localparam longint LUMA_BLACK  = 16;
    localparam longint CHROMA_ZERO = 128;
    localparam int     REPORT_MAX  = 10;

    bit        blue_first = 1'b1;
    bit        with_alpha = 1'b0;
    out_beat_t pixel_queue [$];
    int        mismatches = 0;

    // floor shift, then clamp to a byte
    function automatic logic [7:0] clip_channel(input longint acc);
        longint scaled;
        scaled = acc >>> FRAC;
        if (scaled < 0)
            return 8'd0;
        if (scaled > 255)
            return 8'd255;
        return scaled[7:0];
    endfunction

    task automatic queue_block_pixels(input in_beat_t blk);
        logic [7:0] luma [4];
        longint     u;
        longint     v;
        longint     red_term;
        longint     green_term;
        longint     blue_term;
        longint     yterm;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        out_beat_t  px;
        luma[0] = blk.luma_top_left;
        luma[1] = blk.luma_top_right;
        luma[2] = blk.luma_bottom_left;
        luma[3] = blk.luma_bottom_right;
        u = longint'(blk.chroma_blue) - CHROMA_ZERO;
        v = longint'(blk.chroma_red) - CHROMA_ZERO;
        red_term   = ROUND + CR_TO_RED * v;
        green_term = ROUND + CR_TO_GREEN * v + CB_TO_GREEN * u;
        blue_term  = ROUND + CB_TO_BLUE * u;
        for (int k = 0; k < 4; k++) begin
            yterm = longint'(luma[k]) - LUMA_BLACK;
            if (yterm < 0)
                yterm = 0;
            yterm = yterm * LUMA_GAIN;
            r = clip_channel(yterm + red_term);
            g = clip_channel(yterm + green_term);
            b = clip_channel(yterm + blue_term);
            px.pixel_row   = k[1];
            px.pixel_col   = k[0];
            px.first_byte  = blue_first ? b : r;
            px.second_byte = g;
            px.third_byte  = blue_first ? r : b;
            px.fourth_byte = with_alpha ? 8'hff : 8'h00;
            px.last        = (k == 3);
            pixel_queue.push_back(px);
        end
    endtask

    always @(posedge aclk) begin
        out_beat_t want;
        logic      bad;
        if (!aresetn) begin
            blue_first = 1'b1;
            with_alpha = 1'b0;
            pixel_queue.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_BLUE_FIRST: blue_first = cfg_wr_data;
                    CFG_WITH_ALPHA: with_alpha = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                queue_block_pixels(s_data);
            if (m_valid && m_ready) begin
                if (pixel_queue.size() == 0) begin
                    if (mismatches < REPORT_MAX)
                        $display("%0t: pixel beat with nothing predicted: %h", $time, m_data);
                    mismatches++;
                end else begin
                    want = pixel_queue.pop_front();
                    bad = (m_data.pixel_row !== want.pixel_row)
                        || (m_data.pixel_col !== want.pixel_col)
                        || (m_data.first_byte !== want.first_byte)
                        || (m_data.second_byte !== want.second_byte)
                        || (m_data.third_byte !== want.third_byte)
                        || (m_data.fourth_byte !== want.fourth_byte)
                        || (m_data.last !== want.last);
                    if (bad) begin
                        if (mismatches < REPORT_MAX)
                            $display("%0t: pixel mismatch: expected r%0d c%0d %h %h %h %h last %0d,",
                                     $time, want.pixel_row, want.pixel_col, want.first_byte,
                                     want.second_byte, want.third_byte, want.fourth_byte,
                                     want.last,
                                     " got r%0d c%0d %h %h %h %h last %0d",
                                     m_data.pixel_row, m_data.pixel_col, m_data.first_byte,
                                     m_data.second_byte, m_data.third_byte,
                                     m_data.fourth_byte, m_data.last);
                        mismatches++;
                    end
                end
            end
        end
        fail_count <= mismatches;
        pend_count <= pixel_queue.size();
    end

endmodule

>>> tb/yuv420_to_rgb_converter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_to_rgb_converter_top_tb
// Drives 2x2 luma blocks with shared chroma through the converter under all
// four byte-order/alpha settings, with random idling on both channels and a
// long output stall, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module yuv420_to_rgb_converter_top_tb;
    import yrc_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 10;
    // indexes past the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_beat_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_beat_t            m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic                 cfg_wr_data = 1'b0;

    int fail_count;
    int pend_count;
    bit idle_en = 1'b0;
    bit hold_req = 1'b0;

    always #5 aclk = ~aclk;

    yuv420_to_rgb_converter_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    yrc_pixel_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pend_count  (pend_count)
    );

    // lean toward black level, zero and full scale
    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(8, 24));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic in_beat_t random_block();
        in_beat_t blk;
        blk.luma_top_left     = pick_sample();
        blk.luma_top_right    = pick_sample();
        blk.luma_bottom_left  = pick_sample();
        blk.luma_bottom_right = pick_sample();
        blk.chroma_blue       = pick_sample();
        blk.chroma_red        = pick_sample();
        return blk;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // offer one block and hold it until the beat is taken
    task automatic send_block(input in_beat_t blk);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= blk;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pend_count != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_random(input int count, input bit with_idle);
        for (int i = 0; i < count; i++) begin
            idle_en = with_idle && ((i % 30) < 22);
            send_block(random_block());
        end
        idle_en = 1'b0;
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int n;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                n = 0;
                while (n < HOLD_CYCLES) begin
                    @(posedge aclk);
                    n++;
                end
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        write_reg(CFG_SPARE_A, 1'b1);
        write_reg(CFG_SPARE_B, 1'b1);

        // reset settings: blue first, no alpha
        send_block(in_beat_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        send_block(in_beat_t'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
        send_block(in_beat_t'{8'd15, 8'd16, 8'd17, 8'd235, 8'd128, 8'd128});
        send_block(in_beat_t'{8'd0, 8'd16, 8'd255, 8'd128, 8'd0, 8'd255});
        send_block(in_beat_t'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0});
        send_block(in_beat_t'{8'd255, 8'd0, 8'd128, 8'd16, 8'd0, 8'd0});
        send_block(in_beat_t'{8'h55, 8'haa, 8'haa, 8'h55, 8'h55, 8'haa});
        send_block(in_beat_t'{8'haa, 8'h55, 8'h55, 8'haa, 8'haa, 8'h55});
        send_block(in_beat_t'{8'd235, 8'd235, 8'd235, 8'd235, 8'd240, 8'd240});
        send_block(in_beat_t'{8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16});
        send_block(in_beat_t'{8'd128, 8'd128, 8'd128, 8'd128, 8'd127, 8'd129});
        send_block(in_beat_t'{8'd1, 8'd2, 8'd4, 8'd8, 8'd128, 8'd255});
        send_block(in_beat_t'{8'd32, 8'd64, 8'd128, 8'd254, 8'd255, 8'd128});
        send_block(in_beat_t'{8'd200, 8'd100, 8'd50, 8'd25, 8'd0, 8'd128});
        send_block(in_beat_t'{8'd81, 8'd145, 8'd41, 8'd210, 8'd90, 8'd240});
        drain();

        // red first with alpha; stall the output early so the block backs up
        write_reg(CFG_BLUE_FIRST, 1'b0);
        write_reg(CFG_WITH_ALPHA, 1'b1);
        hold_req = 1'b1;
        run_random(70, 1'b1);
        drain();

        write_reg(CFG_BLUE_FIRST, 1'b1);
        run_random(65, 1'b1);
        drain();

        // last stretch: red first, no alpha, no idling
        write_reg(CFG_BLUE_FIRST, 1'b0);
        write_reg(CFG_WITH_ALPHA, 1'b0);
        run_random(70, 1'b0);
        drain();

        if (fail_count == 0 && pend_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
